[hdl/sddw_pkg.sv]
// shared types and constants for the signed decimal digit writer
// no dependencies
package sddw_pkg;

  localparam int unsigned ValueW  = 16;
  localparam int unsigned MagW    = 15;
  localparam int unsigned PlaceW  = 3;
  localparam int unsigned CodeW   = 4;
  localparam int unsigned QDepth  = 2;
  localparam int unsigned QPtrW   = 1;
  localparam int unsigned QCntW   = 2;

  localparam logic signed [ValueW-1:0] NEG_LIMIT  = -16'sd1000;
  localparam logic [CodeW-1:0]         MINUS_CODE = 4'd10;
  // x / 10 == (x * 52429) >> 19 for every x below 43699
  localparam logic [15:0]              DIV10_MULT = 16'd52429;
  localparam int unsigned              DIV10_SHIFT = 19;
  localparam int unsigned              ProdW = MagW + 16;

  localparam logic [1:0] LAST_DIGIT = 2'd3;

  // one run of four digit writes
  typedef struct packed {
    logic            neg;
    logic [MagW-1:0] mag;
  } sddw_job_t;

endpackage

[hdl/sddw_front.sv]
// front end: classifies a signed value and forms the magnitude job
// depends on sddw_pkg
module sddw_front (
  input  logic signed [sddw_pkg::ValueW-1:0] signed_value,
  output logic                               keep,
  output sddw_pkg::sddw_job_t                job
);
  import sddw_pkg::*;

  logic [ValueW-1:0] neg_val;

  assign neg_val = ValueW'(-signed_value);

  always_comb begin
    job  = '0;
    keep = 1'b0;
    if (!signed_value[ValueW-1]) begin
      keep     = 1'b1;
      job.neg  = 1'b0;
      job.mag  = signed_value[MagW-1:0];
    end else if (signed_value > NEG_LIMIT) begin
      keep     = 1'b1;
      job.neg  = 1'b1;
      job.mag  = neg_val[MagW-1:0];
    end
  end

endmodule

[hdl/sddw_queue.sv]
// two-entry job queue between front and back end
// depends on sddw_pkg
module sddw_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                wr_en,
  input  sddw_pkg::sddw_job_t wr_job,
  output logic                full,
  input  logic                rd_en,
  output logic                nonempty,
  output sddw_pkg::sddw_job_t rd_job
);
  import sddw_pkg::*;

  sddw_job_t        entry_r [QDepth];
  logic [QPtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCntW-1:0] cnt_r, cnt_nxt;
  logic             do_wr, do_rd;

  assign full     = (cnt_r == QCntW'(QDepth));
  assign nonempty = (cnt_r != '0);
  assign rd_job   = entry_r[rd_ptr_r];
  assign do_wr    = wr_en && !full;
  assign do_rd    = rd_en && nonempty;

  always_comb begin
    wr_ptr_nxt = do_wr ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_rd ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      entry_r[wr_ptr_r] <= wr_job;
    end
  end

endmodule

[hdl/sddw_back.sv]
// back end: peels one decimal digit a cycle into the output register unless the output stalls
// depends on sddw_pkg
module sddw_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        job_avail,
  input  sddw_pkg::sddw_job_t         job,
  output logic                        job_take,
  output logic                        out_empty,
  input  logic                        out_pop,
  output logic [sddw_pkg::PlaceW-1:0] out_digit_place,
  output logic [sddw_pkg::CodeW-1:0]  out_digit_code,
  output logic                        out_last_of_run
);
  import sddw_pkg::*;

  logic              busy_r, busy_nxt;
  logic              neg_r;
  logic [MagW-1:0]   mag_r;
  logic [1:0]        cnt_r, cnt_nxt;
  logic              valid_r, valid_nxt;
  logic [PlaceW-1:0] place_r;
  logic [CodeW-1:0]  code_r;
  logic              last_r;

  logic              step, load;
  logic [ProdW-1:0]  prod;
  logic [MagW-1:0]   quot;
  logic [MagW-1:0]   quot_x10;
  logic [MagW-1:0]   rem_full;

  assign out_empty       = !valid_r;
  assign out_digit_place = place_r;
  assign out_digit_code  = code_r;
  assign out_last_of_run = last_r;

  // reciprocal divide by ten
  assign prod     = ProdW'(mag_r) * ProdW'(DIV10_MULT);
  assign quot     = MagW'(prod >> DIV10_SHIFT);
  assign quot_x10 = (quot << 3) + (quot << 1);
  assign rem_full = mag_r - quot_x10;

  assign step     = busy_r && (!valid_r || out_pop);
  assign load     = !busy_r || (step && cnt_r == LAST_DIGIT);
  assign job_take = load && job_avail;

  always_comb begin
    busy_nxt  = busy_r;
    cnt_nxt   = cnt_r;
    valid_nxt = valid_r;
    if (step) begin
      valid_nxt = 1'b1;
      cnt_nxt   = cnt_r + 1'b1;
    end else if (out_pop) begin
      valid_nxt = 1'b0;
    end
    if (load) begin
      busy_nxt = job_avail;
      cnt_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      cnt_r   <= '0;
      valid_r <= 1'b0;
    end else begin
      busy_r  <= busy_nxt;
      cnt_r   <= cnt_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (job_take) begin
      neg_r <= job.neg;
      mag_r <= job.mag;
    end else if (step) begin
      mag_r <= quot;
    end
    if (step) begin
      place_r <= PlaceW'(cnt_r) + 1'b1;
      last_r  <= (cnt_r == LAST_DIGIT);
      // minus sign takes the top place of a negative run
      code_r  <= (neg_r && cnt_r == LAST_DIGIT) ? MINUS_CODE : rem_full[CodeW-1:0];
    end
  end

endmodule

[hdl/signed_decimal_digit_writer.sv]
// throughput: one digit write per cycle unless the output stalls or no job is queued, four per value
// the digit unit (one divide by ten a cycle) sets the rate; values of -1000 or
// less are taken and make no writes
// reset (synchronous, rst_n low) empties the job queue and the output register
module signed_decimal_digit_writer (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_push,
  output logic                               in_full,
  input  logic signed [sddw_pkg::ValueW-1:0] in_signed_value,
  output logic                               out_empty,
  input  logic                               out_pop,
  output logic [sddw_pkg::PlaceW-1:0]        out_digit_place,
  output logic [sddw_pkg::CodeW-1:0]         out_digit_code,
  output logic                               out_last_of_run
);
  import sddw_pkg::*;

  logic      keep;
  sddw_job_t front_job;
  sddw_job_t q_job;
  logic      q_full, q_nonempty, q_take;

  assign in_full = q_full;

  sddw_front u_front (
    .signed_value (in_signed_value),
    .keep         (keep),
    .job          (front_job)
  );

  sddw_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (in_push && keep),
    .wr_job   (front_job),
    .full     (q_full),
    .rd_en    (q_take),
    .nonempty (q_nonempty),
    .rd_job   (q_job)
  );

  sddw_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .job_avail       (q_nonempty),
    .job             (q_job),
    .job_take        (q_take),
    .out_empty       (out_empty),
    .out_pop         (out_pop),
    .out_digit_place (out_digit_place),
    .out_digit_code  (out_digit_code),
    .out_last_of_run (out_last_of_run)
  );

endmodule

[hdl/sddw_checker.sv]
// port-level checks for the signed decimal digit writer, bound to the top level
// depends on sddw_pkg
module sddw_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        out_empty,
  input logic                        out_pop,
  input logic [sddw_pkg::PlaceW-1:0] out_digit_place,
  input logic [sddw_pkg::CodeW-1:0]  out_digit_code,
  input logic                        out_last_of_run
);
  import sddw_pkg::*;

  a_place_range: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> (out_digit_place >= 3'd1 && out_digit_place <= 3'd4))
    else $error("digit place out of range");

  a_last_at_top: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> (out_last_of_run == (out_digit_place == 3'd4)))
    else $error("end-of-run mark not on the top place");

  a_minus_place: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_digit_code == MINUS_CODE) |-> out_digit_place == 3'd4)
    else $error("minus sign below the top place");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_digit_place)
      && $stable(out_digit_code) && $stable(out_last_of_run)))
    else $error("stalled beat changed");

endmodule

bind signed_decimal_digit_writer sddw_checker u_sddw_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_empty       (out_empty),
  .out_pop         (out_pop),
  .out_digit_place (out_digit_place),
  .out_digit_code  (out_digit_code),
  .out_last_of_run (out_last_of_run)
);
